// ===== src/rfrf_pkg.sv =====
// Shared types and constants for the rotated framebuffer rectangle fill block.
// No dependencies; every other file in src imports this package.
package rfrf_pkg;

  // Field widths sized for the largest supported panel (64 x 256).
  localparam int unsigned ROW_W  = 6;  // panel row, up to 64 rows
  localparam int unsigned PAGE_W = 3;  // page = row / 8, up to 8 pages
  localparam int unsigned COL_W  = 8;  // panel column, up to 256 columns
  localparam int unsigned IDX_W  = 9;  // byte index field of a read item

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_FLIP    = 1'b0,
    REG_PRESENT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLEAR,
    BK_FILL_RD,
    BK_FILL_WR,
    BK_READ
  } back_state_e;

  // Classified command, already clipped and rotated into panel space.
  typedef struct packed {
    kind_e              kind;
    logic               set_on;
    logic               hit;     // fill touches at least one pixel
    logic [ROW_W-1:0]   row_lo;
    logic [ROW_W-1:0]   row_hi;
    logic [COL_W-1:0]   col_lo;
    logic [COL_W-1:0]   col_hi;
    logic [IDX_W-1:0]   byte_index;
  } cmd_t;

endpackage

// ===== src/rfrf_front.sv =====
// Front end: takes command transfers, clips and rotates fill rectangles.
// Depends on rfrf_pkg; feeds rfrf_fifo.
module rfrf_front #(
  parameter int unsigned SHORT_SIDE = 32,
  parameter int unsigned LONG_SIDE  = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                flip_i,
  input  logic                init_busy_i,
  input  logic                fifo_full_i,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic signed [7:0]   left_i,
  input  logic signed [15:0]  top_i,
  input  logic [7:0]          width_i,
  input  logic [7:0]          height_i,
  input  logic                set_on_i,
  input  logic [8:0]          byte_index_i,
  output logic                push_o,
  output rfrf_pkg::cmd_t      cmd_o
);
  import rfrf_pkg::*;

  localparam logic signed [9:0]  XMAX = 10'(SHORT_SIDE);
  localparam logic signed [17:0] YMAX = 18'(LONG_SIDE);

  logic               valid_q, valid_d;
  cmd_t               cmd_q, cmd_d;
  logic               accept;
  logic signed [9:0]  x_end, x0, x1, r_lo, r_hi;
  logic signed [17:0] y_end, y0, y1, c_lo, c_hi;

  assign busy   = init_busy_i || (valid_q && fifo_full_i);
  assign accept = start && !busy;
  assign push_o = valid_q && !fifo_full_i;
  assign cmd_o  = cmd_q;

  always_comb begin
    // clip in portrait space, both ends half open
    x_end = $signed({{2{left_i[7]}}, left_i}) + $signed({2'b00, width_i});
    x0    = left_i[7] ? 10'sd0 : $signed({2'b00, left_i});
    x1    = (x_end > XMAX) ? XMAX : x_end;
    y_end = $signed({{2{top_i[15]}}, top_i}) + $signed({10'd0, height_i});
    y0    = top_i[15] ? 18'sd0 : $signed({2'b00, top_i});
    y1    = (y_end > YMAX) ? YMAX : y_end;

    if (flip_i) begin
      r_lo = x0;
      r_hi = x1 - 10'sd1;
      c_lo = YMAX - y1;
      c_hi = YMAX - 18'sd1 - y0;
    end else begin
      r_lo = XMAX - x1;
      r_hi = XMAX - 10'sd1 - x0;
      c_lo = y0;
      c_hi = y1 - 18'sd1;
    end

    cmd_d.kind       = kind_e'(kind_i);
    cmd_d.set_on     = set_on_i;
    cmd_d.hit        = (x0 < x1) && (y0 < y1);
    cmd_d.row_lo     = r_lo[ROW_W-1:0];
    cmd_d.row_hi     = r_hi[ROW_W-1:0];
    cmd_d.col_lo     = c_lo[COL_W-1:0];
    cmd_d.col_hi     = c_hi[COL_W-1:0];
    cmd_d.byte_index = byte_index_i;

    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== src/rfrf_fifo.sv =====
// Short command queue between front end and back end.
// Depends on rfrf_pkg for the command type and depth.
module rfrf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rfrf_pkg::cmd_t  push_data_i,
  input  logic            pop_i,
  output rfrf_pkg::cmd_t  head_o,
  output logic            full_o,
  output logic            empty_o
);
  import rfrf_pkg::*;

  cmd_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/rfrf_back.sv =====
// Back end: owns the frame store and dirty flag, executes queued commands.
// Depends on rfrf_pkg; reads commands from rfrf_fifo.
module rfrf_back #(
  parameter int unsigned SHORT_SIDE = 32,
  parameter int unsigned LONG_SIDE  = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            present_i,
  input  rfrf_pkg::cmd_t  cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            init_busy_o,
  output logic            done_o,
  output logic [7:0]      read_data_o,
  output logic            flush_due_o
);
  import rfrf_pkg::*;

  localparam int unsigned PAGES       = (SHORT_SIDE + 7) / 8;
  localparam int unsigned STORE_BYTES = PAGES * LONG_SIDE;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);

  back_state_e       state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              dirty_q, dirty_d;
  logic              done_q, done_d;
  logic [7:0]        rdata_q, rdata_d;
  logic              due_q, due_d;

  logic [7:0]        mem_q [STORE_BYTES];
  logic [7:0]        mem_rd_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_ra, mem_wa, fill_addr;
  logic [7:0]        mem_wd, mask;
  logic [ROW_W-1:0]  row;

  assign init_busy_o = (state_q == BK_INIT);
  assign done_o      = done_q;
  assign read_data_o = rdata_q;
  assign flush_due_o = due_q;

  assign fill_addr = ADDR_W'(32'(page_q) * LONG_SIDE + 32'(col_q));

  // rows of the current page that lie inside the rectangle
  always_comb begin
    row  = '0;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      row     = {page_q, 3'(b)};
      mask[b] = (row >= cur_q.row_lo) && (row <= cur_q.row_hi);
    end
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    page_d  = page_q;
    col_d   = col_q;
    clr_d   = clr_q;
    dirty_d = dirty_q;
    done_d  = 1'b0;
    rdata_d = '0;
    due_d   = 1'b0;
    pop_o   = 1'b0;
    mem_re  = 1'b0;
    mem_ra  = fill_addr;
    mem_we  = 1'b0;
    mem_wa  = clr_q;
    mem_wd  = '0;

    case (state_q)
      BK_INIT: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          clr_d   = '0;
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          case (cmd_i.kind)
            KIND_CLEAR: begin
              clr_d   = '0;
              state_d = BK_CLEAR;
            end
            KIND_FILL: begin
              if (cmd_i.hit) begin
                page_d  = cmd_i.row_lo[ROW_W-1:3];
                col_d   = cmd_i.col_lo;
                state_d = BK_FILL_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            KIND_FLUSH: begin
              done_d = 1'b1;
              due_d  = dirty_q && present_i;
              if (dirty_q && present_i) begin
                dirty_d = 1'b0;
              end
            end
            KIND_READ: begin
              if (32'(cmd_i.byte_index) < STORE_BYTES) begin
                mem_re  = 1'b1;
                mem_ra  = ADDR_W'(cmd_i.byte_index);
                state_d = BK_READ;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      BK_CLEAR: begin
        mem_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          clr_d   = '0;
          dirty_d = 1'b1;
          done_d  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      BK_FILL_RD: begin
        mem_re  = 1'b1;
        state_d = BK_FILL_WR;
      end
      BK_FILL_WR: begin
        mem_we  = 1'b1;
        mem_wa  = fill_addr;
        mem_wd  = cur_q.set_on ? (mem_rd_q | mask) : (mem_rd_q & ~mask);
        state_d = BK_FILL_RD;
        if (col_q == cur_q.col_hi) begin
          if (page_q == cur_q.row_hi[ROW_W-1:3]) begin
            dirty_d = 1'b1;
            done_d  = 1'b1;
            state_d = BK_IDLE;
          end else begin
            page_d = page_q + 1'b1;
            col_d  = cur_q.col_lo;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      BK_READ: begin
        done_d  = 1'b1;
        rdata_d = mem_rd_q;
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      clr_q   <= '0;
      dirty_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      dirty_q <= dirty_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    page_q  <= page_d;
    col_q   <= col_d;
    rdata_q <= rdata_d;
    due_q   <= due_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_ra];
    end
  end

endmodule

// ===== src/rotated_framebuffer_rect_fill.sv =====
// Top level of the rotated framebuffer rectangle fill block.
// Depends on rfrf_pkg, rfrf_front, rfrf_fifo and rfrf_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  command   | start / busy         | kind_i left_i top_i width_i height_i
//            |                      | set_on_i byte_index_i
//  result    | done_o (strobe)      | read_data_o flush_due_o
//  config    | cfg_we_i / cfg_idx_i | cfg_wdata_i (flip, display present)
//
// A command transfer happens on a clock edge with start high and busy low.
// Every command yields exactly one result, shown for one cycle with done_o.
// Work per command in the back end: a clear writes zero to every store
// byte in turn, a read fetches one byte, a flush or a fully clipped fill
// is answered from idle, and a fill reads each touched byte, then writes it.
// After reset the back end sweeps every store byte to zero; busy stays
// high during that pass. Config writes are taken always.
// The front end and a two-entry queue absorb commands while the back end
// works; busy rises once both are full. The result side cannot stall.
module rotated_framebuffer_rect_fill #(
  parameter int unsigned SHORT_SIDE = 32,
  parameter int unsigned LONG_SIDE  = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind_i,
  input  logic signed [7:0]  left_i,
  input  logic signed [15:0] top_i,
  input  logic [7:0]         width_i,
  input  logic [7:0]         height_i,
  input  logic               set_on_i,
  input  logic [8:0]         byte_index_i,
  // result channel
  output logic               done_o,
  output logic [7:0]         read_data_o,
  output logic               flush_due_o,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic               cfg_wdata_i
);
  import rfrf_pkg::*;

  logic flip_q, flip_d;
  logic present_q, present_d;

  cmd_t front_cmd, head_cmd;
  logic push, pop, fifo_full, fifo_empty, init_busy;

  // config registers; only legal while idle, so no hazard with queued work
  always_comb begin
    flip_d    = flip_q;
    present_d = present_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FLIP:    flip_d    = cfg_wdata_i;
        REG_PRESENT: present_d = cfg_wdata_i;
        default:     flip_d    = flip_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q    <= 1'b0;
      present_q <= 1'b0;
    end else begin
      flip_q    <= flip_d;
      present_q <= present_d;
    end
  end

  // classify, clip and rotate into panel space
  rfrf_front #(
    .SHORT_SIDE (SHORT_SIDE),
    .LONG_SIDE  (LONG_SIDE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flip_i       (flip_q),
    .init_busy_i  (init_busy),
    .fifo_full_i  (fifo_full),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .left_i       (left_i),
    .top_i        (top_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .set_on_i     (set_on_i),
    .byte_index_i (byte_index_i),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  rfrf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  // frame store, dirty flag and result generation
  rfrf_back #(
    .SHORT_SIDE (SHORT_SIDE),
    .LONG_SIDE  (LONG_SIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .present_i   (present_q),
    .cmd_i       (head_cmd),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .flush_due_o (flush_due_o)
  );

endmodule

// ===== tb/sv/rotated_framebuffer_rect_fill_tb.sv =====
// Self-checking testbench for rotated_framebuffer_rect_fill.
// Depends on rfrf_pkg and the block's RTL; a scoreboard class shadows the
// framebuffer and the dirty flag, and a directed run precedes random phases.
module rotated_framebuffer_rect_fill_tb;
  import rfrf_pkg::*;

  localparam int unsigned SHORT_SIDE  = 32;
  localparam int unsigned LONG_SIDE   = 128;
  localparam int unsigned PAGES       = (SHORT_SIDE + 7) / 8;
  localparam int unsigned STORE_BYTES = PAGES * LONG_SIDE;
  localparam int unsigned MAX_REPORTS = 10;
  // Quiet time after the last reply; catches stray done strobes.
  localparam int unsigned TAIL_CYCLES = 40;

  // One reply per command: the read byte and the flush flag.
  typedef struct packed {
    logic [7:0] read_data;
    logic       flush_due;
  } fb_reply_t;

  // Shadow of the panel store plus the dirty flag and the two registers.
  // apply_command updates the shadow for each accepted command transfer and
  // queues the reply it owes; check_reply pops the oldest owed reply.
  class framebuffer_scoreboard;
    logic [7:0] shadow_frame [STORE_BYTES];
    bit         dirty;
    bit         flip;
    bit         present;
    fb_reply_t  awaited_replies [$];
    int unsigned mismatches;

    function new();
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      dirty      = 1'b0;
      flip       = 1'b0;
      present    = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic value);
      if (idx == REG_FLIP) begin
        flip = value;
      end else begin
        present = value;
      end
    endfunction

    // Portrait (x,y) to panel column/row, then one bit of a page byte.
    function void paint_pixel(int x, int y, bit on);
      int col;
      int row;
      int addr;
      if (flip) begin
        col = int'(LONG_SIDE) - 1 - y;
        row = x;
      end else begin
        col = y;
        row = int'(SHORT_SIDE) - 1 - x;
      end
      addr = (row / 8) * int'(LONG_SIDE) + col;
      shadow_frame[addr][row % 8] = on;
    endfunction

    function void apply_command(kind_e kind, logic signed [7:0] left,
                                logic signed [15:0] top, logic [7:0] w,
                                logic [7:0] h, logic on, logic [8:0] idx);
      fb_reply_t reply;
      int x0;
      int x1;
      int y0;
      int y1;
      reply = '0;
      case (kind)
        KIND_CLEAR: begin
          foreach (shadow_frame[i]) shadow_frame[i] = '0;
          dirty = 1'b1;
        end
        KIND_FILL: begin
          // clip to the screen; off-screen pixels never wrap back
          x0 = (int'(left) < 0) ? 0 : int'(left);
          x1 = int'(left) + int'(w);
          if (x1 > int'(SHORT_SIDE)) x1 = SHORT_SIDE;
          y0 = (int'(top) < 0) ? 0 : int'(top);
          y1 = int'(top) + int'(h);
          if (y1 > int'(LONG_SIDE)) y1 = LONG_SIDE;
          if (x0 < x1 && y0 < y1) begin
            for (int x = x0; x < x1; x++) begin
              for (int y = y0; y < y1; y++) paint_pixel(x, y, on);
            end
            dirty = 1'b1;
          end
        end
        KIND_FLUSH: begin
          if (dirty && present) begin
            reply.flush_due = 1'b1;
            dirty = 1'b0;
          end
        end
        default: begin
          if (idx < STORE_BYTES) reply.read_data = shadow_frame[idx];
        end
      endcase
      awaited_replies.push_back(reply);
    endfunction

    function void check_reply(logic [7:0] read_data, logic flush_due);
      fb_reply_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: reply with no command outstanding: data %02h due %b",
                   read_data, flush_due);
        return;
      end
      want = awaited_replies.pop_front();
      if (read_data !== want.read_data || flush_due !== want.flush_due) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: read_data exp %02h got %02h, flush_due exp %b got %b",
                   want.read_data, read_data, want.flush_due, flush_due);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         kind_i;
  logic signed [7:0]  left_i;
  logic signed [15:0] top_i;
  logic [7:0]         width_i;
  logic [7:0]         height_i;
  logic               set_on_i;
  logic [8:0]         byte_index_i;
  logic               done_o;
  logic [7:0]         read_data_o;
  logic               flush_due_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic               cfg_wdata_i;

  framebuffer_scoreboard sb;

  rotated_framebuffer_rect_fill #(
    .SHORT_SIDE(SHORT_SIDE),
    .LONG_SIDE (LONG_SIDE)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .left_i      (left_i),
    .top_i       (top_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .set_on_i    (set_on_i),
    .byte_index_i(byte_index_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .flush_due_o (flush_due_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog. Its limit is sized for the slowest legal run: roughly 950
  // full-screen fills plus sender gaps and the reset sweep.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The reply side cannot stall: every done strobe is one reply transfer.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_reply(read_data_o, flush_due_o);
  end

  // Drive one command at the falling edge and hold it until a rising edge
  // sees start high with busy low. start stays high, so back-to-back calls
  // give back-to-back transfers.
  task automatic send_command(kind_e kind, logic signed [7:0] left,
                              logic signed [15:0] top, logic [7:0] w,
                              logic [7:0] h, logic on, logic [8:0] idx);
    @(negedge clk_i);
    start        <= 1'b1;
    kind_i       <= kind;
    left_i       <= left;
    top_i        <= top;
    width_i      <= w;
    height_i     <= h;
    set_on_i     <= on;
    byte_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.apply_command(kind, left, top, w, h, on, idx);
  endtask

  task automatic pause_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Every command owes a reply, so an empty queue means the block is idle.
  task automatic drain_replies();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random commands. Fills are mostly sprite sized near the screen so they
  // land on pixels; one in ten has wild coordinates, one in twenty a wild
  // size, to hit clipping and the long walks.
  task automatic run_phase(int unsigned count, bit with_gaps);
    kind_e              kind;
    logic signed [7:0]  left;
    logic signed [15:0] top;
    logic [7:0]         w;
    logic [7:0]         h;
    logic               on;
    logic [8:0]         idx;
    int unsigned        pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        kind = KIND_CLEAR;
      end else if (pick < 47) begin
        kind = KIND_FILL;
      end else if (pick < 60) begin
        kind = KIND_FLUSH;
      end else begin
        kind = KIND_READ;
      end
      if ($urandom_range(0, 9) == 0) left = 8'($urandom);
      else left = 8'($urandom_range(0, 44) - 6);
      if ($urandom_range(0, 9) == 0) top = 16'($urandom);
      else top = 16'($urandom_range(0, 143) - 8);
      if ($urandom_range(0, 19) == 0) w = 8'($urandom);
      else w = 8'($urandom_range(0, 12));
      if ($urandom_range(0, 19) == 0) h = 8'($urandom);
      else h = 8'($urandom_range(0, 16));
      on  = ($urandom_range(0, 3) != 0);
      idx = 9'($urandom);
      send_command(kind, left, top, w, h, on, idx);
      if (with_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind_i       = KIND_CLEAR;
    left_i       = '0;
    top_i        = '0;
    width_i      = '0;
    height_i     = '0;
    set_on_i     = 1'b0;
    byte_index_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_FLIP;
    cfg_wdata_i  = 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, default orientation, no display. The block is still in its
    // clearing sweep here, so the first transfer waits on busy.
    write_reg(REG_FLIP, 1'b0);
    write_reg(REG_PRESENT, 1'b0);
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);             // clean store
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd0);
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd511);
    // fully clipped at both extremes: must not mark dirty
    send_command(KIND_FILL, 8'sh80, 16'sh8000, 8'hFF, 8'hFF, 1'b1, 0);
    send_command(KIND_FILL, 8'sh7F, 16'sh7FFF, 8'hFF, 8'hFF, 1'b1, 0);
    send_command(KIND_FILL, 0, 0, 8'd0, 8'd20, 1'b1, 0);       // empty width
    send_command(KIND_FILL, 0, 0, 8'd20, 8'd0, 1'b1, 0);       // empty height
    send_command(KIND_FILL, 0, 0, 8'd32, 8'd128, 1'b1, 0);     // whole screen
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);             // no display
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd0);
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd511);
    send_command(KIND_FILL, -8'sd3, -16'sd5, 8'd8, 8'd10, 1'b0, 0); // partial clip
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd0);
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd387);

    // Display present: dirty left over from above makes a flush due once.
    drain_replies();
    write_reg(REG_PRESENT, 1'b1);
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);
    send_command(KIND_CLEAR, 0, 0, 0, 0, 1'b0, 0);
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);
    send_command(KIND_FILL, 8'sd31, 16'sd127, 8'd1, 8'd1, 1'b1, 0);
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd127);

    // Flipped orientation: single pixels at two corners.
    drain_replies();
    write_reg(REG_FLIP, 1'b1);
    send_command(KIND_FILL, 8'sd0, 16'sd0, 8'd1, 8'd1, 1'b1, 0);
    send_command(KIND_FILL, 8'sd31, 16'sd0, 8'd1, 8'd1, 1'b1, 0);
    send_command(KIND_READ, 0, 0, 0, 0, 1'b0, 9'd511);
    send_command(KIND_FLUSH, 0, 0, 0, 0, 1'b0, 0);

    // Random phases: all four register combinations first, then random
    // settings; the final phase runs with both registers set and no sender gaps.
    for (int p = 0; p < 8; p++) begin
      drain_replies();
      if (p < 4) begin
        write_reg(REG_FLIP, p[0]);
        write_reg(REG_PRESENT, p[1]);
      end else if (p < 7) begin
        write_reg(REG_FLIP, 1'($urandom_range(0, 1)));
        write_reg(REG_PRESENT, 1'($urandom_range(0, 1)));
      end else begin
        write_reg(REG_FLIP, 1'b1);
        write_reg(REG_PRESENT, 1'b1);
      end
      run_phase(115, p != 7);
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rfrf_pkg.sv
src/rfrf_front.sv
src/rfrf_fifo.sv
src/rfrf_back.sv
src/rotated_framebuffer_rect_fill.sv
tb/sv/rotated_framebuffer_rect_fill_tb.sv
